// ===== src/standard_address_filter_macros.svh =====
// assertion macros for the standard address filter
// each macro samples on aclk and is disabled while aresetn is low
`ifndef STANDARD_ADDRESS_FILTER_MACROS_SVH
`define STANDARD_ADDRESS_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SAF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("standard_address_filter: same-cycle check failed");
// next-cycle implication
`define SAF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("standard_address_filter: next-cycle check failed");
`else
`define SAF_ASSERT_IMP(label, ante, cons)
`define SAF_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== src/saf_pkg.sv =====
package saf_pkg;

    localparam int HOST_ENTRIES_DEF = 64;
    localparam int WILD_ENTRIES_DEF = 32;

    localparam int ADDR_W = 32;

    // register index as decoded from paddr[2]
    localparam logic REG_CHECK_ENABLED = 1'b0;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // one item as it travels down the cell chain
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic              grant;
        logic              wild;       // add targets the wildcard cells
        logic              done;       // verdict or placement already decided
        logic              permitted;
        status_t           status;
    } item_t;

endpackage

// ===== src/saf_cell.sv =====
`include "standard_address_filter_macros.svh"

module saf_cell #(
    parameter bit IS_WILD = 1'b0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_vld,
    input  saf_pkg::item_t  in_item,
    output logic            out_vld,
    output saf_pkg::item_t  out_item
);

    logic                          ent_vld_reg;
    logic                          ent_vld_next;
    logic [saf_pkg::ADDR_W-1:0]    ent_base_reg;
    logic [saf_pkg::ADDR_W-1:0]    ent_mask;
    logic                          ent_grant_reg;
    logic                          ent_wr;
    logic                          stg_vld_reg;
    saf_pkg::item_t                stg_item_reg;
    saf_pkg::item_t                stg_item_next;
    logic                          hit;
    logic                          same;

    // host cells hold no mask
    if (IS_WILD) begin : g_mask
        logic [saf_pkg::ADDR_W-1:0] ent_mask_reg;
        always_ff @(posedge aclk) begin
            if (adv && ent_wr) begin
                ent_mask_reg <= in_item.mask;
            end
        end
        assign ent_mask = ent_mask_reg;
    end else begin : g_nomask
        assign ent_mask = '0;
    end

    assign hit  = ent_vld_reg && ((in_item.addr & ~ent_mask) == ent_base_reg);
    assign same = ent_vld_reg && (ent_base_reg == in_item.addr)
                  && (ent_mask == in_item.mask) && (ent_grant_reg == in_item.grant);

    always_comb begin
        stg_item_next = in_item;
        ent_vld_next  = ent_vld_reg;
        ent_wr        = 1'b0;
        if (in_vld) begin
            case (in_item.op)
                saf_pkg::OP_LOOKUP: begin
                    if (!in_item.done && hit) begin
                        stg_item_next.done      = 1'b1;
                        stg_item_next.permitted = ent_grant_reg;
                    end
                end
                saf_pkg::OP_ADD: begin
                    if (!in_item.done && (in_item.wild == IS_WILD)) begin
                        if (same) begin
                            stg_item_next.done   = 1'b1;
                            stg_item_next.status = saf_pkg::ST_DUP;
                        end else if (!ent_vld_reg) begin
                            // first free cell: entries stay packed from the head
                            ent_wr               = 1'b1;
                            ent_vld_next         = 1'b1;
                            stg_item_next.done   = 1'b1;
                            stg_item_next.status = saf_pkg::ST_DONE;
                        end
                    end
                end
                saf_pkg::OP_CLEAR: begin
                    ent_vld_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= 1'b0;
            stg_vld_reg <= 1'b0;
        end else if (adv) begin
            ent_vld_reg <= ent_vld_next;
            stg_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stg_item_reg <= stg_item_next;
        end
        if (adv && ent_wr) begin
            ent_base_reg  <= in_item.addr;
            ent_grant_reg <= in_item.grant;
        end
    end

    assign out_vld  = stg_vld_reg;
    assign out_item = stg_item_reg;

    // an entry only goes away through a clear
    `SAF_ASSERT_NXT(a_entry_kept,
        ent_vld_reg && !(adv && in_vld && in_item.op == saf_pkg::OP_CLEAR),
        ent_vld_reg)
    // a cell never writes over a stored entry
    `SAF_ASSERT_IMP(a_no_overwrite, ent_wr, !ent_vld_reg)

endmodule

// ===== src/standard_address_filter.sv =====
// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+----------------------------------------------
// s_        | in        | s_valid / s_ready | s_operation, s_address, s_wildcard_mask, s_grant
// m_        | out       | m_valid / m_ready | m_permitted, m_status
// apb       | in        | psel / penable    | paddr, pwdata, prdata (check_enabled at 0x0)
//
// one transfer can be taken every cycle while s_ready is high; each item passes the input
// stage and then walks the chain of entry cells, one cell per cycle while the chain advances,
// and m_valid rises when the item leaves the last cell
// the whole chain moves as one: while a result waits on m_ready, no stage advances
// reset (synchronous, aresetn low) empties both lists at once through the per-cell
// valid bits and clears check_enabled; no clearing pass follows
`include "standard_address_filter_macros.svh"

module standard_address_filter #(
    parameter int HOST_ENTRIES = saf_pkg::HOST_ENTRIES_DEF,
    parameter int WILD_ENTRIES = saf_pkg::WILD_ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_operation,
    input  logic [saf_pkg::ADDR_W-1:0] s_address,
    input  logic [saf_pkg::ADDR_W-1:0] s_wildcard_mask,
    input  logic                       s_grant,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_permitted,
    output logic [1:0]                 m_status,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CELLS = HOST_ENTRIES + WILD_ENTRIES;

    // configuration and list state kept at the chain entry
    logic            check_enabled_reg;
    logic            list_present_reg;
    logic            list_present_next;

    // input stage
    logic            in_vld_reg;
    saf_pkg::item_t  in_item_reg;
    saf_pkg::item_t  in_item_next;

    logic            adv;
    logic            s_xfer;
    saf_pkg::op_t    s_op;

    // links between the cells: index 0 is the input stage, CELLS the last cell
    logic            link_vld  [0:CELLS];
    saf_pkg::item_t  link_item [0:CELLS];
    saf_pkg::item_t  tail;

    // -------------------------------------------------------------------------
    // apb register port: one register, writes land in the access phase
    // -------------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == saf_pkg::REG_CHECK_ENABLED)
                    ? {31'b0, check_enabled_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_enabled_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == saf_pkg::REG_CHECK_ENABLED)) begin
            check_enabled_reg <= pwdata[0];
        end
    end

    // -------------------------------------------------------------------------
    // global advance: every stage moves unless a finished result is stuck
    // -------------------------------------------------------------------------
    assign adv     = !link_vld[CELLS] || m_ready;
    assign s_ready = adv;
    assign s_xfer  = s_valid && s_ready;
    assign s_op    = saf_pkg::op_t'(s_operation);

    // -------------------------------------------------------------------------
    // input stage: format the item and settle the cases that need no cell
    // -------------------------------------------------------------------------
    always_comb begin
        in_item_next           = '0;
        in_item_next.op        = s_op;
        in_item_next.addr      = s_address;
        in_item_next.mask      = s_wildcard_mask;
        in_item_next.grant     = s_grant;
        in_item_next.wild      = (s_wildcard_mask != '0);
        in_item_next.status    = saf_pkg::ST_DONE;
        list_present_next      = list_present_reg;
        case (s_op)
            saf_pkg::OP_LOOKUP: begin
                // checking off or no list: permit without walking the entries
                if (!check_enabled_reg || !list_present_reg) begin
                    in_item_next.done      = 1'b1;
                    in_item_next.permitted = 1'b1;
                end
            end
            saf_pkg::OP_ADD: begin
                // don't-care bits are stored cleared
                in_item_next.addr = s_address & ~s_wildcard_mask;
                list_present_next = 1'b1;
            end
            saf_pkg::OP_CLEAR: begin
                list_present_next = 1'b0;
            end
            default: begin
                // unused code: passes through with no effect
                in_item_next.done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg       <= 1'b0;
            list_present_reg <= 1'b0;
        end else begin
            if (adv) begin
                in_vld_reg <= s_valid;
            end
            if (s_xfer) begin
                list_present_reg <= list_present_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_item_reg <= in_item_next;
        end
    end

    assign link_vld[0]  = in_vld_reg;
    assign link_item[0] = in_item_reg;

    // -------------------------------------------------------------------------
    // the cell chain: host cells first, wildcard cells after, in insertion order
    // -------------------------------------------------------------------------
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        saf_cell #(
            .IS_WILD (i >= HOST_ENTRIES)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_vld   (link_vld[i]),
            .in_item  (link_item[i]),
            .out_vld  (link_vld[i+1]),
            .out_item (link_item[i+1])
        );
    end

    // -------------------------------------------------------------------------
    // result: an add that found neither a duplicate nor a free cell was dropped;
    // a lookup that matched nothing keeps permitted low (deny)
    // -------------------------------------------------------------------------
    assign tail        = link_item[CELLS];
    assign m_valid     = link_vld[CELLS];
    assign m_permitted = tail.permitted;
    assign m_status    = (tail.op == saf_pkg::OP_ADD && !tail.done)
                         ? saf_pkg::ST_FULL : tail.status;

    // any add creates the list, even a duplicate or a dropped one
    `SAF_ASSERT_NXT(a_add_sets_list,
        s_xfer && s_operation == saf_pkg::OP_ADD,
        list_present_reg)
    // with checking off a lookup is permitted at the chain entry
    `SAF_ASSERT_NXT(a_bypass_permit,
        s_xfer && s_operation == saf_pkg::OP_LOOKUP && !check_enabled_reg,
        in_vld_reg && in_item_reg.done && in_item_reg.permitted)
    // only an add reports duplicate or full
    `SAF_ASSERT_IMP(a_status_add_only,
        m_valid && m_status != saf_pkg::ST_DONE,
        tail.op == saf_pkg::OP_ADD && !m_permitted)
    // a held result keeps the whole chain still
    `SAF_ASSERT_NXT(a_stall_holds_input,
        in_vld_reg && m_valid && !m_ready,
        in_vld_reg && $stable(in_item_reg))

endmodule
